[rtl/core/fpcr_pkg.sv]
package fpcr_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_DIM_W  = 11;

  localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_FORMAT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROTATE_VERT    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIENT_FLIPPED = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIRROR_VERT    = 3'd5;

  // source pixel formats
  localparam logic [1:0] FMT_555 = 2'd0;
  localparam logic [1:0] FMT_565 = 2'd1;
  localparam logic [1:0] FMT_888 = 2'd2;
  localparam logic [1:0] FMT_8888 = 2'd3;

  localparam logic [1:0] FORMAT_RESET = FMT_565;
  localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 11'd240;

  // command kinds
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam int PIX_W = 32;

  typedef logic [PIX_W-1:0] pixel_t;

  // widen a source pixel to 32 bits; 555 and 565 channels are filled by replicating top bits
  function automatic pixel_t widen(input logic [1:0] fmt, input pixel_t p);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = {p[4:0], p[4:2]};
    b1 = '0;
    b2 = '0;
    unique case (fmt)
      FMT_555: begin
        b1 = {p[9:5], p[9:7]};
        b2 = {p[14:10], p[14:12]};
        return {8'h00, b2, b1, b0};
      end
      FMT_565: begin
        b1 = {p[10:5], p[10:9]};
        b2 = {p[15:11], p[15:13]};
        return {8'h00, b2, b1, b0};
      end
      FMT_888: return {8'h00, p[23:0]};
      FMT_8888: return p;
    endcase
  endfunction

endpackage

[rtl/core/fpcr_ram.sv]
module fpcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/frame_pixel_convert_rotate.sv]
// Frame pixel converter with rotation. A word on the input carries a command in
// in_tuser: a load widens in_tdata to 32 bits and stores it at the rotated,
// flipped or mirrored position in the frame store; a read returns the next
// stored pixel in raster order on out_tdata, with out_tlast on the last pixel
// of the frame. A load does a position update, then the address multiply and
// store write; a read does the store read, then loads the output register,
// which waits while the output word is valid and out_tready is low. One item
// is in work at a time. After each configuration write the input is not ready
// in the cycle after it while the frame size product is updated; the input is
// likewise not ready in the first cycle after reset. The store is not
// cleared: reading a pixel that was never loaded returns an arbitrary value.
module frame_pixel_convert_rotate #(
  parameter int MAX_DIM    = 1024,
  parameter int MAX_PIXELS = 1048576
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: pixel_in[31:0]
  input  logic [31:0]                       in_tdata,
  // in_tuser: cmd[0]
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: pixel_out[31:0]
  output logic [31:0]                       out_tdata,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [fpcr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [fpcr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int IW = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int AW = $clog2(MAX_PIXELS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WRITE = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;

  // configuration registers
  logic [1:0]                       fmt_r;
  logic [fpcr_pkg::CFG_DIM_W-1:0]   width_r;
  logic [fpcr_pkg::CFG_DIM_W-1:0]   height_r;
  logic                             rot_r;
  logic                             flip_r;
  logic                             mirror_r;
  logic                             cfg_hold_r;

  logic [1:0]              state_r, state_nxt;
  logic [DW-1:0]           col_r, col_nxt;
  logic [DW-1:0]           row_r, row_nxt;
  logic [IW-1:0]           rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]           total_r;
  logic [DW-1:0]           dx_r, dx_nxt;
  logic [DW-1:0]           dy_r, dy_nxt;
  fpcr_pkg::pixel_t        pix_r;
  logic                    last_r, last_nxt;
  logic                    in_range_r, in_range_nxt;
  fpcr_pkg::pixel_t        out_data_r;
  logic                    out_last_r;
  logic                    out_valid_r;

  logic [DW-1:0]           w_c, h_c;
  logic                    accept, load_acc, read_acc, out_load;
  logic [IW-1:0]           addr_full;
  logic [IW-1:0]           rd_idx;
  logic                    ram_we;
  fpcr_pkg::pixel_t        ram_rdata;

  // clamp sizes to 1..MAX_DIM
  assign w_c = (width_r == '0) ? DW'(1) :
               (32'(width_r) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(width_r);
  assign h_c = (height_r == '0) ? DW'(1) :
               (32'(height_r) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(height_r);

  assign in_tready = (state_r == S_IDLE) && !cfg_hold_r;
  assign accept    = in_tvalid && in_tready;
  assign load_acc  = accept && (in_tuser == fpcr_pkg::CMD_LOAD);
  assign read_acc  = accept && (in_tuser == fpcr_pkg::CMD_READ);
  assign out_load  = (state_r == S_READ) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r      <= fpcr_pkg::FORMAT_RESET;
      width_r    <= fpcr_pkg::WIDTH_RESET;
      height_r   <= fpcr_pkg::HEIGHT_RESET;
      rot_r      <= 1'b0;
      flip_r     <= 1'b0;
      mirror_r   <= 1'b0;
      cfg_hold_r <= 1'b1;
    end else begin
      cfg_hold_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_addr)
          fpcr_pkg::CFG_PIXEL_FORMAT:   fmt_r    <= cfg_wdata[1:0];
          fpcr_pkg::CFG_FRAME_WIDTH:    width_r  <= cfg_wdata;
          fpcr_pkg::CFG_FRAME_HEIGHT:   height_r <= cfg_wdata;
          fpcr_pkg::CFG_ROTATE_VERT:    rot_r    <= cfg_wdata[0];
          fpcr_pkg::CFG_ORIENT_FLIPPED: flip_r   <= cfg_wdata[0];
          fpcr_pkg::CFG_MIRROR_VERT:    mirror_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // frame size product, registered from the clamped frame sizes
  always_ff @(posedge clk) begin
    total_r <= IW'(w_c) * IW'(h_c);
  end

  // load position: wrap counters, then map to destination coordinates
  always_comb begin
    logic [DW-1:0] len, rows, c, r, c1, r1, dy_t;
    len  = rot_r ? h_c : w_c;
    rows = rot_r ? w_c : h_c;
    c    = (col_r >= len) ? '0 : col_r;
    r    = (row_r >= rows) ? '0 : row_r;
    if (rot_r) begin
      if (flip_r) begin
        dx_nxt = w_c - DW'(1) - r;
        dy_t   = c;
      end else begin
        dx_nxt = r;
        dy_t   = h_c - DW'(1) - c;
      end
    end else if (flip_r) begin
      dx_nxt = w_c - DW'(1) - c;
      dy_t   = h_c - DW'(1) - r;
    end else begin
      dx_nxt = c;
      dy_t   = r;
    end
    dy_nxt = mirror_r ? (h_c - DW'(1) - dy_t) : dy_t;
    c1 = c + DW'(1);
    r1 = r + DW'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (load_acc) begin
      if (c1 >= len) begin
        col_nxt = '0;
        row_nxt = (r1 >= rows) ? '0 : r1;
      end else begin
        col_nxt = c1;
        row_nxt = r;
      end
    end
  end

  // readout index
  always_comb begin
    rd_idx       = (rd_idx_r >= total_r) ? '0 : rd_idx_r;
    last_nxt     = (rd_idx == total_r - IW'(1));
    in_range_nxt = (32'(rd_idx) < 32'(MAX_PIXELS));
    rd_idx_nxt   = rd_idx_r;
    if (read_acc) begin
      rd_idx_nxt = last_nxt ? '0 : rd_idx + IW'(1);
    end
  end

  assign addr_full = IW'(dy_r) * IW'(w_c) + IW'(dx_r);
  assign ram_we    = (state_r == S_WRITE) && (32'(addr_full) < 32'(MAX_PIXELS));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (load_acc) begin
          state_nxt = S_WRITE;
        end else if (read_acc) begin
          state_nxt = S_READ;
        end
      end
      S_WRITE: state_nxt = S_IDLE;
      S_READ: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      pix_r <= fpcr_pkg::widen(fmt_r, in_tdata);
    end
    if (read_acc) begin
      last_r     <= last_nxt;
      in_range_r <= in_range_nxt;
    end
    if (out_load) begin
      out_data_r <= in_range_r ? ram_rdata : '0;
      out_last_r <= last_r;
    end
  end

  fpcr_ram #(
    .WIDTH (fpcr_pkg::PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(addr_full)),
    .wdata (pix_r),
    .re    (read_acc),
    .raddr (AW'(rd_idx)),
    .rdata (ram_rdata)
  );

  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input ready right after a config write");

  a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
    read_acc |=> (state_r == S_READ))
    else $error("accepted read did not start a store read");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == S_READ))
    else $error("output word appeared without a store read");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    read_acc |=> !ram_we)
    else $error("store write overlapped a read");

endmodule
